[rtl/rsp_pkg.sv]
// Types, constants and register codes shared by the rain/snow partition block.
`default_nettype none
package rsp_pkg;

  localparam int unsigned TEMP_W   = 16;
  localparam int unsigned AMT_W    = 20;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned SFRAC_W  = FRAC_W + 1;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 20;

  // The divider retires two quotient bits per stage.
  localparam int unsigned DIV_STAGES = FRAC_W / 2;

  localparam logic [TEMP_W-1:0] FREEZE_CK     = 16'd27315;
  localparam logic [TEMP_W-1:0] ABOVE_FREEZE  = 16'd27316;
  localparam logic [TEMP_W-1:0] BELOW_FREEZE  = 16'd27314;

  localparam logic [MONTH_W-1:0] SUMMER_FIRST = 4'd6;
  localparam logic [MONTH_W-1:0] SUMMER_LAST  = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_ALL_SNOW_TEMP  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALL_RAIN_TEMP  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TINY_AMOUNT    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_FRACTION = 4'd3;

  localparam logic [TEMP_W-1:0]  RST_ALL_SNOW_TEMP  = 16'd27315;
  localparam logic [TEMP_W-1:0]  RST_ALL_RAIN_TEMP  = 16'd27615;
  localparam logic [AMT_W-1:0]   RST_TINY_AMOUNT    = 20'd1;
  localparam logic [SFRAC_W-1:0] RST_SMALL_FRACTION = 17'd66;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_RAIN = 2'd1,
    KIND_SNOW = 2'd2,
    KIND_MIX  = 2'd3
  } precip_kind_e;

  typedef struct packed {
    logic [MONTH_W-1:0] month;
    logic [AMT_W-1:0]   precip_total;
    logic [TEMP_W-1:0]  temp_max;
    logic [TEMP_W-1:0]  temp_mean;
    logic [TEMP_W-1:0]  temp_min;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        precip_type;
    logic              storm_type;
    logic [AMT_W-1:0]  rain_amount;
    logic [AMT_W-1:0]  snow_amount;
    logic [TEMP_W-1:0] rain_temp;
    logic [TEMP_W-1:0] snow_temp;
  } out_item_t;

  typedef struct packed {
    logic [TEMP_W-1:0]  all_snow_temp;
    logic [TEMP_W-1:0]  all_rain_temp;
    logic [AMT_W-1:0]   tiny_amount;
    logic [SFRAC_W-1:0] small_fraction;
  } cfg_t;

  // Word carried alongside the divider: early class, storm flag, total amount and candidate temperatures.
  typedef struct packed {
    precip_kind_e      kind;
    logic              storm;
    logic [AMT_W-1:0]  precip;
    logic [TEMP_W-1:0] train_rain;
    logic [TEMP_W-1:0] train_mix;
    logic [TEMP_W-1:0] tsnow_snow;
    logic [TEMP_W-1:0] tsnow_mix;
  } carry_t;

endpackage
`default_nettype wire

[rtl/rsp_classify.sv]
// First stage: early classification, division operands and candidate temperatures.
`default_nettype none
module rsp_classify (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  input  wire rsp_pkg::in_item_t       item_i,
  input  wire rsp_pkg::cfg_t           cfg_i,
  output logic                         valid_o,
  output rsp_pkg::carry_t              carry_o,
  output logic [rsp_pkg::TEMP_W-1:0]   above_o,
  output logic [rsp_pkg::TEMP_W-1:0]   span_o
);
  import rsp_pkg::*;

  logic                valid_q;
  carry_t              carry_d, carry_q;
  logic [TEMP_W-1:0]   above_d, above_q;
  logic [TEMP_W-1:0]   span_d, span_q;
  logic [TEMP_W:0]     sum_mean_rain, sum_mean_snow, sum_min_snow;
  logic [TEMP_W-1:0]   half_mean_rain, half_mean_snow, half_min_snow;
  logic [TEMP_W-1:0]   tsnow_cold, train_warm;

  always_comb begin
    sum_mean_rain  = {1'b0, item_i.temp_mean} + {1'b0, cfg_i.all_rain_temp};
    sum_mean_snow  = {1'b0, item_i.temp_mean} + {1'b0, cfg_i.all_snow_temp};
    sum_min_snow   = {1'b0, item_i.temp_min} + {1'b0, cfg_i.all_snow_temp};
    half_mean_rain = sum_mean_rain[TEMP_W:1];
    half_mean_snow = sum_mean_snow[TEMP_W:1];
    half_min_snow  = sum_min_snow[TEMP_W:1];

    train_warm = (half_mean_rain < FREEZE_CK) ? ABOVE_FREEZE : half_mean_rain;
    tsnow_cold = (half_min_snow >= FREEZE_CK) ? BELOW_FREEZE : half_min_snow;

    carry_d.train_rain = (item_i.temp_mean > FREEZE_CK) ? item_i.temp_mean : train_warm;
    carry_d.train_mix  = train_warm;
    carry_d.tsnow_snow = (item_i.temp_mean < FREEZE_CK) ? item_i.temp_mean : tsnow_cold;
    carry_d.tsnow_mix  = (half_mean_snow < FREEZE_CK) ? half_mean_snow : tsnow_cold;

    carry_d.precip = item_i.precip_total;
    carry_d.storm  = (item_i.month >= SUMMER_FIRST) && (item_i.month <= SUMMER_LAST);

    priority if (item_i.precip_total < cfg_i.tiny_amount) begin
      carry_d.kind = KIND_NONE;
    end else if (item_i.temp_min >= cfg_i.all_snow_temp) begin
      carry_d.kind = KIND_RAIN;
    end else if (item_i.temp_max <= cfg_i.all_snow_temp) begin
      carry_d.kind = KIND_SNOW;
    end else begin
      carry_d.kind = KIND_MIX;
    end

    // Only meaningful for a mixture, where max > threshold > min.
    above_d = item_i.temp_max - cfg_i.all_snow_temp;
    span_d  = item_i.temp_max - item_i.temp_min;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    above_q <= above_d;
    span_q  <= span_d;
  end

  assign valid_o = valid_q;
  assign carry_o = carry_q;
  assign above_o = above_q;
  assign span_o  = span_q;

endmodule
`default_nettype wire

[rtl/rsp_div.sv]
// Pipelined restoring divider for the Q16 rain fraction, two quotient bits per stage.
`default_nettype none
module rsp_div (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  input  wire rsp_pkg::carry_t         carry_i,
  input  wire logic [rsp_pkg::TEMP_W-1:0] above_i,
  input  wire logic [rsp_pkg::TEMP_W-1:0] span_i,
  output logic                         valid_o,
  output rsp_pkg::carry_t              carry_o,
  output logic [rsp_pkg::FRAC_W-1:0]   frac_o
);
  import rsp_pkg::*;

  typedef struct packed {
    logic [TEMP_W-1:0] rem;
    logic              qbit;
  } div_step_t;

  // One shift-and-subtract step; the partial remainder stays below span as long as it starts below span.
  function automatic div_step_t div_step(input logic [TEMP_W-1:0] rem,
                                         input logic [TEMP_W-1:0] span);
    logic [TEMP_W:0] shifted;
    logic [TEMP_W:0] diff;
    div_step_t       res;
    shifted  = {rem, 1'b0};
    diff     = shifted - {1'b0, span};
    res.qbit = (shifted >= {1'b0, span});
    res.rem  = res.qbit ? diff[TEMP_W-1:0] : shifted[TEMP_W-1:0];
    return res;
  endfunction

  logic              vld_q   [DIV_STAGES];
  carry_t            carry_q [DIV_STAGES];
  logic [TEMP_W-1:0] rem_q   [DIV_STAGES];
  logic [TEMP_W-1:0] span_q  [DIV_STAGES];
  logic [FRAC_W-1:0] quot_q  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic              vld_in;
    carry_t            carry_in;
    logic [TEMP_W-1:0] rem_in;
    logic [TEMP_W-1:0] span_in;
    logic [FRAC_W-1:0] quot_in;
    div_step_t         step_a, step_b;

    if (s == 0) begin : g_first
      assign vld_in   = valid_i;
      assign carry_in = carry_i;
      assign rem_in   = above_i;
      assign span_in  = span_i;
      assign quot_in  = '0;
    end else begin : g_next
      assign vld_in   = vld_q[s-1];
      assign carry_in = carry_q[s-1];
      assign rem_in   = rem_q[s-1];
      assign span_in  = span_q[s-1];
      assign quot_in  = quot_q[s-1];
    end

    always_comb begin
      step_a = div_step(rem_in, span_in);
      step_b = div_step(step_a.rem, span_in);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      carry_q[s] <= carry_in;
      rem_q[s]   <= step_b.rem;
      span_q[s]  <= span_in;
      quot_q[s]  <= {quot_in[FRAC_W-3:0], step_a.qbit, step_b.qbit};
    end
  end

  assign valid_o = vld_q[DIV_STAGES-1];
  assign carry_o = carry_q[DIV_STAGES-1];
  assign frac_o  = quot_q[DIV_STAGES-1];

endmodule
`default_nettype wire

[rtl/rsp_split.sv]
// Last two stages: rain amount product, threshold checks and result word assembly.
`default_nettype none
module rsp_split (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  input  wire rsp_pkg::carry_t         carry_i,
  input  wire logic [rsp_pkg::FRAC_W-1:0] frac_i,
  input  wire rsp_pkg::cfg_t           cfg_i,
  output logic                         valid_o,
  output rsp_pkg::out_item_t           result_o
);
  import rsp_pkg::*;

  localparam int unsigned PROD_W = AMT_W + FRAC_W;

  // Product stage.
  logic               mul_vld_q;
  carry_t             mul_carry_q;
  logic               small_d, small_q;
  logic [PROD_W-1:0]  prod;
  logic [AMT_W-1:0]   rain_d, rain_q;

  // Result stage.
  logic               out_vld_q;
  out_item_t          out_d, out_q;
  precip_kind_e       kind;
  logic [AMT_W-1:0]   snow_part;

  always_comb begin
    small_d = ({1'b0, frac_i} < cfg_i.small_fraction);
    prod    = {{FRAC_W{1'b0}}, carry_i.precip} * {{AMT_W{1'b0}}, frac_i};
    rain_d  = prod[PROD_W-1:FRAC_W];
  end

  always_comb begin
    // The fraction is below one, so the rain part never exceeds the total.
    snow_part = mul_carry_q.precip - rain_q;
    kind      = mul_carry_q.kind;
    if (mul_carry_q.kind == KIND_MIX) begin
      priority if (small_q || (rain_q < cfg_i.tiny_amount)) begin
        kind = KIND_SNOW;
      end else if (snow_part < cfg_i.tiny_amount) begin
        kind = KIND_RAIN;
      end else begin
        kind = KIND_MIX;
      end
    end

    out_d.precip_type = kind;
    out_d.storm_type  = mul_carry_q.storm;
    unique case (kind)
      KIND_RAIN: begin
        out_d.rain_amount = mul_carry_q.precip;
        out_d.snow_amount = '0;
        out_d.rain_temp   = mul_carry_q.train_rain;
        out_d.snow_temp   = FREEZE_CK;
      end
      KIND_SNOW: begin
        out_d.rain_amount = '0;
        out_d.snow_amount = mul_carry_q.precip;
        out_d.rain_temp   = FREEZE_CK;
        out_d.snow_temp   = mul_carry_q.tsnow_snow;
      end
      KIND_MIX: begin
        out_d.rain_amount = rain_q;
        out_d.snow_amount = snow_part;
        out_d.rain_temp   = mul_carry_q.train_mix;
        out_d.snow_temp   = mul_carry_q.tsnow_mix;
      end
      default: begin
        out_d.rain_amount = '0;
        out_d.snow_amount = '0;
        out_d.rain_temp   = FREEZE_CK;
        out_d.snow_temp   = FREEZE_CK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      mul_vld_q <= valid_i;
      out_vld_q <= mul_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_carry_q <= carry_i;
    small_q     <= small_d;
    rain_q      <= rain_d;
    out_q       <= out_d;
  end

  assign valid_o  = out_vld_q;
  assign result_o = out_q;

endmodule
`default_nettype wire

[rtl/rain_snow_partition.sv]
// Throughput: one word per clock; busy stays low, so start may be held high every cycle.
// Latency is set by the eight-stage fraction divider plus classify, product and result stages.
// Reset clears all stage valid bits and loads the configuration registers with their defaults.
// The receiver cannot stall; done_o marks each result for exactly one cycle.
`default_nettype none
module rain_snow_partition (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire rsp_pkg::in_item_t             item_i,
  output logic                               done_o,
  output rsp_pkg::out_item_t                 result_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rsp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [rsp_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rsp_pkg::*;

  cfg_t              cfg_q;
  logic              accept;
  logic              cls_valid, div_valid;
  carry_t            cls_carry, div_carry;
  logic [TEMP_W-1:0] cls_above, cls_span;
  logic [FRAC_W-1:0] div_frac;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.all_snow_temp  <= RST_ALL_SNOW_TEMP;
      cfg_q.all_rain_temp  <= RST_ALL_RAIN_TEMP;
      cfg_q.tiny_amount    <= RST_TINY_AMOUNT;
      cfg_q.small_fraction <= RST_SMALL_FRACTION;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ALL_SNOW_TEMP:  cfg_q.all_snow_temp  <= cfg_data_i[TEMP_W-1:0];
        CFG_ALL_RAIN_TEMP:  cfg_q.all_rain_temp  <= cfg_data_i[TEMP_W-1:0];
        CFG_TINY_AMOUNT:    cfg_q.tiny_amount    <= cfg_data_i[AMT_W-1:0];
        CFG_SMALL_FRACTION: cfg_q.small_fraction <= {1'b0, cfg_data_i[FRAC_W-1:0]} |
                                                    {cfg_data_i[FRAC_W], {FRAC_W{1'b0}}};
        default: ;
      endcase
    end
  end

  rsp_classify u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .item_i  (item_i),
    .cfg_i   (cfg_q),
    .valid_o (cls_valid),
    .carry_o (cls_carry),
    .above_o (cls_above),
    .span_o  (cls_span)
  );

  rsp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cls_valid),
    .carry_i (cls_carry),
    .above_i (cls_above),
    .span_i  (cls_span),
    .valid_o (div_valid),
    .carry_o (div_carry),
    .frac_o  (div_frac)
  );

  rsp_split u_split (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (div_valid),
    .carry_i  (div_carry),
    .frac_i   (div_frac),
    .cfg_i    (cfg_q),
    .valid_o  (done_o),
    .result_o (result_o)
  );

endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the rain/snow partition block.
module tb_top;
  import rsp_pkg::*;

  localparam int LATENCY_PAD = 16;
  localparam int DRAIN_LIMIT = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SHOWN_MAX   = 10;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  in_item_t              item_i      = '0;
  logic                  done_o;
  out_item_t             result_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  cfg_t        thresholds;
  out_item_t   pending_parts[$];
  int unsigned faults = 0;
  int unsigned cycles = 0;
  int          gap_pct = 0;

  rain_snow_partition dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [TEMP_W-1:0] half_of(logic [TEMP_W-1:0] a, logic [TEMP_W-1:0] b);
    logic [TEMP_W:0] total;
    total = {1'b0, a} + {1'b0, b};
    return total[TEMP_W:1];
  endfunction

  // Splits one word into rain and snow under the given thresholds.
  function automatic out_item_t partition_item(in_item_t it, cfg_t c);
    out_item_t        r;
    precip_kind_e     kind;
    logic [AMT_W-1:0] rain, snow, rain_part;
    logic [63:0]      span, above, frac, prod;
    logic [TEMP_W-1:0] t_rain, t_snow;
    rain = '0;
    snow = '0;
    if (it.precip_total < c.tiny_amount) begin
      kind = KIND_NONE;
    end else if (it.temp_min >= c.all_snow_temp) begin
      kind = KIND_RAIN;
      rain = it.precip_total;
    end else if (it.temp_max <= c.all_snow_temp) begin
      kind = KIND_SNOW;
      snow = it.precip_total;
    end else begin
      span  = 64'(it.temp_max) - 64'(it.temp_min);
      above = 64'(it.temp_max) - 64'(c.all_snow_temp);
      frac  = (above << FRAC_W) / span;
      if (frac < 64'(c.small_fraction)) begin
        kind = KIND_SNOW;
        snow = it.precip_total;
      end else begin
        prod = 64'(it.precip_total) * frac;
        rain_part = AMT_W'(prod >> FRAC_W);
        if (rain_part < c.tiny_amount) begin
          kind = KIND_SNOW;
          snow = it.precip_total;
        end else if (it.precip_total - rain_part < c.tiny_amount) begin
          kind = KIND_RAIN;
          rain = it.precip_total;
        end else begin
          kind = KIND_MIX;
          rain = rain_part;
          snow = it.precip_total - rain_part;
        end
      end
    end

    t_rain = FREEZE_CK;
    t_snow = FREEZE_CK;
    case (kind)
      KIND_RAIN: begin
        t_rain = it.temp_mean;
        if (t_rain <= FREEZE_CK) begin
          t_rain = half_of(it.temp_mean, c.all_rain_temp);
          if (t_rain < FREEZE_CK) t_rain = ABOVE_FREEZE;
        end
      end
      KIND_SNOW: begin
        t_snow = it.temp_mean;
        if (t_snow >= FREEZE_CK) begin
          t_snow = half_of(it.temp_min, c.all_snow_temp);
          if (t_snow >= FREEZE_CK) t_snow = BELOW_FREEZE;
        end
      end
      KIND_MIX: begin
        t_rain = half_of(it.temp_mean, c.all_rain_temp);
        if (t_rain < FREEZE_CK) t_rain = ABOVE_FREEZE;
        t_snow = half_of(it.temp_mean, c.all_snow_temp);
        if (t_snow >= FREEZE_CK) begin
          t_snow = half_of(it.temp_min, c.all_snow_temp);
          if (t_snow >= FREEZE_CK) t_snow = BELOW_FREEZE;
        end
      end
      default: ;
    endcase

    r.precip_type = kind;
    r.storm_type  = (it.month >= SUMMER_FIRST) && (it.month <= SUMMER_LAST);
    r.rain_amount = rain;
    r.snow_amount = snow;
    r.rain_temp   = t_rain;
    r.snow_temp   = t_snow;
    return r;
  endfunction

  function automatic in_item_t item_of(logic [MONTH_W-1:0] m, logic [AMT_W-1:0] p,
                                       logic [TEMP_W-1:0] hi, logic [TEMP_W-1:0] mean,
                                       logic [TEMP_W-1:0] lo);
    in_item_t it;
    it.month        = m;
    it.precip_total = p;
    it.temp_max     = hi;
    it.temp_mean    = mean;
    it.temp_min     = lo;
    return it;
  endfunction

  // Most words straddle the snow threshold so that the fraction path is exercised.
  function automatic in_item_t make_item(cfg_t c);
    in_item_t it;
    int thr, lim, tmin, tmax, tmean, p;
    thr  = int'(c.all_snow_temp);
    lim  = ($urandom_range(0, 1) == 0) ? 40 : 8000;
    tmax = $urandom_range(0, 65535);
    tmin = $urandom_range(0, 65535);
    case ($urandom_range(0, 9))
      0: ;
      1, 2, 3, 4, 5, 6: begin
        if (thr > 0 && thr < 65535) begin
          tmin = thr - int'($urandom_range(1, (thr < lim) ? thr : lim));
          tmax = thr + int'($urandom_range(1, (65535 - thr < lim) ? 65535 - thr : lim));
        end
      end
      7: begin
        tmin = $urandom_range(thr, 65535);
        tmax = $urandom_range(tmin, 65535);
      end
      8: begin
        tmax = $urandom_range(0, thr);
        tmin = $urandom_range(0, tmax);
      end
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          tmin = thr;
          tmax = $urandom_range(thr, 65535);
        end else begin
          tmax = thr;
          tmin = $urandom_range(0, thr);
        end
      end
    endcase
    case ($urandom_range(0, 2))
      0:       tmean = $urandom_range(0, 65535);
      1:       tmean = $urandom_range(tmin, tmax);
      default: tmean = int'(FREEZE_CK) + int'($urandom_range(0, 800)) - 400;
    endcase
    case ($urandom_range(0, 3))
      0, 1: p = $urandom_range(0, 1048575);
      2:    p = $urandom_range(0, 200);
      default: begin
        p = int'(c.tiny_amount) + int'($urandom_range(0, 40)) - 20;
        if (p < 0) p = 0;
        if (p > 1048575) p = 1048575;
      end
    endcase
    it.month        = MONTH_W'($urandom_range(0, 15));
    it.precip_total = AMT_W'(p);
    it.temp_max     = TEMP_W'(tmax);
    it.temp_mean    = TEMP_W'(tmean);
    it.temp_min     = TEMP_W'(tmin);
    return it;
  endfunction

  function automatic cfg_t make_config();
    cfg_t c;
    c.all_snow_temp = ($urandom_range(0, 7) == 0) ? TEMP_W'($urandom)
                                                  : TEMP_W'($urandom_range(25315, 29315));
    c.all_rain_temp = ($urandom_range(0, 7) == 0) ? TEMP_W'($urandom)
                                                  : TEMP_W'($urandom_range(25315, 29315));
    case ($urandom_range(0, 3))
      0:       c.tiny_amount = AMT_W'($urandom_range(0, 3));
      1:       c.tiny_amount = AMT_W'($urandom_range(0, 100));
      2:       c.tiny_amount = AMT_W'($urandom_range(0, 20000));
      default: c.tiny_amount = AMT_W'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       c.small_fraction = SFRAC_W'($urandom_range(0, 200));
      1:       c.small_fraction = SFRAC_W'($urandom_range(0, 65536));
      2:       c.small_fraction = SFRAC_W'($urandom);
      default: c.small_fraction = SFRAC_W'($urandom_range(60000, 65536));
    endcase
    return c;
  endfunction

  // Offers one word and books its expected result once the block takes it.
  task automatic send_item(input in_item_t it);
    logic [95:0] noise;
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    pending_parts.push_back(partition_item(it, thresholds));
    if (int'($urandom_range(1, 100)) <= gap_pct) begin
      noise = {$urandom, $urandom, $urandom};
      start  <= 1'b0;
      item_i <= noise[$bits(in_item_t)-1:0];
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // Waits for every booked result, then lets the pipeline run empty.
  task automatic settle();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (pending_parts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_parts.size() != 0) begin
      faults += pending_parts.size();
      $display("%0d expected results never arrived", pending_parts.size());
      pending_parts.delete();
    end
    repeat (LATENCY_PAD) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ALL_SNOW_TEMP:  thresholds.all_snow_temp  = data[TEMP_W-1:0];
      CFG_ALL_RAIN_TEMP:  thresholds.all_rain_temp  = data[TEMP_W-1:0];
      CFG_TINY_AMOUNT:    thresholds.tiny_amount    = data[AMT_W-1:0];
      CFG_SMALL_FRACTION: thresholds.small_fraction = data[SFRAC_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Unused upper data bits carry noise; the block must drop them.
  task automatic apply_config(input cfg_t c);
    settle();
    cfg_write(CFG_ALL_SNOW_TEMP, {4'($urandom), c.all_snow_temp});
    cfg_write(CFG_ALL_RAIN_TEMP, {4'($urandom), c.all_rain_temp});
    cfg_write(CFG_TINY_AMOUNT, c.tiny_amount);
    cfg_write(CFG_SMALL_FRACTION, {3'($urandom), c.small_fraction});
  endtask

  task automatic send_random(input int count);
    repeat (count) send_item(make_item(thresholds));
  endtask

  task automatic test_reset_defaults();
    gap_pct = 20;
    send_item(item_of(4'd0, 20'd0, 16'd30000, 16'd28000, 16'd27000));
    send_item(item_of(4'd6, 20'hFFFFF, 16'd30000, 16'd30000, 16'd30000));
    send_item(item_of(4'd8, 20'd1, 16'd28000, 16'd27000, 16'd27315));
    send_item(item_of(4'd7, 20'd5000, 16'd28000, 16'd27315, 16'd27500));
    send_item(item_of(4'd5, 20'd5000, 16'd27315, 16'd27000, 16'd26000));
    send_item(item_of(4'd9, 20'd5000, 16'd27315, 16'd27315, 16'd27315));
    send_item(item_of(4'd12, 20'd5000, 16'd20000, 16'd40000, 16'd20000));
    send_item(item_of(4'd1, 20'd100000, 16'd28315, 16'd27315, 16'd26315));
    send_item(item_of(4'd13, 20'd100000, 16'd28315, 16'd20000, 16'd26315));
    // Fraction one step below and exactly at the small-fraction threshold.
    send_item(item_of(4'd15, 20'd1000, 16'd27316, 16'd27000, 16'd26316));
    send_item(item_of(4'd2, 20'd1000000, 16'd27316, 16'd27000, 16'd26324));
    send_item(item_of(4'd3, 20'd1, 16'd28315, 16'd27315, 16'd26315));
    send_item(item_of(4'd4, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'h0));
    send_item(item_of(4'd10, 20'hFFFFF, 16'h0, 16'h0, 16'h0));
    send_item(item_of(4'd11, 20'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(item_of(4'd14, 20'd3, 16'd28315, 16'd27500, 16'd26315));
    send_item(item_of(4'd6, 20'hFFFFF, 16'd27400, 16'd27350, 16'd27314));
  endtask

  task automatic test_threshold_extremes();
    cfg_t corner[5];
    corner[0] = '{all_snow_temp: '0, all_rain_temp: '0, tiny_amount: '0, small_fraction: '0};
    corner[1] = '{all_snow_temp: '1, all_rain_temp: '1, tiny_amount: '1, small_fraction: '1};
    corner[2] = '{all_snow_temp: 16'd40000, all_rain_temp: 16'd40000,
                  tiny_amount: 20'd1000, small_fraction: 17'd65536};
    corner[3] = '{all_snow_temp: 16'd27315, all_rain_temp: 16'd0,
                  tiny_amount: 20'd500, small_fraction: 17'd0};
    corner[4] = '{all_snow_temp: 16'd27315, all_rain_temp: 16'd27615,
                  tiny_amount: 20'd300000, small_fraction: 17'd65535};
    gap_pct = 30;
    foreach (corner[i]) begin
      apply_config(corner[i]);
      send_random(60);
    end
  endtask

  task automatic test_tiny_amount();
    apply_config('{all_snow_temp: 16'd27315, all_rain_temp: 16'd27615,
                   tiny_amount: 20'd500, small_fraction: 17'd66});
    gap_pct = 20;
    send_item(item_of(4'd3, 20'd499, 16'd30000, 16'd30000, 16'd30000));
    send_item(item_of(4'd3, 20'd500, 16'd30000, 16'd30000, 16'd30000));
    // Snow share under the tiny amount turns into all rain.
    send_item(item_of(4'd7, 20'd1000, 16'd40000, 16'd27000, 16'd27314));
    // Rain share under the tiny amount turns into all snow.
    send_item(item_of(4'd9, 20'd900, 16'd28315, 16'd27000, 16'd26315));
    send_item(item_of(4'd9, 20'd1000, 16'd28315, 16'd27000, 16'd26315));
    send_random(40);
  endtask

  task automatic test_unused_index();
    settle();
    for (int i = int'(CFG_SMALL_FRACTION) + 1; i < (1 << CFG_IDX_W); i++) begin
      cfg_write(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    end
    gap_pct = 10;
    send_random(40);
  endtask

  task automatic test_random_partition();
    for (int phase = 0; phase < 12; phase++) begin
      apply_config(make_config());
      for (int burst = 0; burst < 2; burst++) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 10;
          default: gap_pct = 40;
        endcase
        send_random(48);
      end
    end
  endtask

  task automatic test_back_to_back();
    apply_config(make_config());
    gap_pct = 0;
    send_random(200);
  endtask

  // Results cannot be held off, so every strobe is checked at the edge that ends it.
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    logic      same;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_parts.size() == 0) begin
        faults++;
        if (faults <= SHOWN_MAX) $display("result word with no expectation pending");
      end else begin
        want = pending_parts.pop_front();
        same = (result_o.precip_type === want.precip_type) &&
               (result_o.storm_type  === want.storm_type)  &&
               (result_o.rain_amount === want.rain_amount) &&
               (result_o.snow_amount === want.snow_amount) &&
               (result_o.rain_temp   === want.rain_temp)   &&
               (result_o.snow_temp   === want.snow_temp);
        if (!same) begin
          faults++;
          if (faults <= SHOWN_MAX) begin
            $display("mismatch: expected type %0d storm %0d rain %0d snow %0d rt %0d st %0d",
                     want.precip_type, want.storm_type, want.rain_amount,
                     want.snow_amount, want.rain_temp, want.snow_temp);
            $display("          actual   type %0d storm %0d rain %0d snow %0d rt %0d st %0d",
                     result_o.precip_type, result_o.storm_type, result_o.rain_amount,
                     result_o.snow_amount, result_o.rain_temp, result_o.snow_temp);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    thresholds = '{all_snow_temp: RST_ALL_SNOW_TEMP, all_rain_temp: RST_ALL_RAIN_TEMP,
                   tiny_amount: RST_TINY_AMOUNT, small_fraction: RST_SMALL_FRACTION};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_threshold_extremes();
    test_tiny_amount();
    test_unused_index();
    test_random_partition();
    test_back_to_back();
    settle();
    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
